// ===== src/frp_pkg.sv =====
package frp_pkg;

   // largest run of results one frame can give
   localparam int RUN_LIMIT = 64;
   localparam int BUFFER_DEPTH_DEF = 64;

   // register indexes on the csr port
   localparam logic [1:0] CSR_HEADER = 2'd0;
   localparam logic [1:0] CSR_FOOTER = 2'd1;
   localparam logic [1:0] CSR_MAX_LEN = 2'd2;

   localparam logic [7:0] HEADER_RESET = 8'd170;
   localparam logic [7:0] FOOTER_RESET = 8'd85;
   localparam logic [6:0] MAX_LEN_RESET = 7'd64;

   // one good frame waiting for replay
   typedef struct packed {
      logic [15:0] ptype;
      logic [6:0]  plen;
      logic        bank;
   } frame_desc_type;

   // payload store write from the parser
   typedef struct packed {
      logic       en;
      logic       bank;
      logic [5:0] idx;
      logic [7:0] data;
   } store_wr_type;

endpackage

// ===== src/framed_packet_receiver.sv =====
// channel   | ports                                   | direction
// request   | req_valid, req_ready, req_rx_byte       | in
// result    | rsp_valid, rsp_ready, rsp_packet_type,  | out
//           | rsp_packet_length, rsp_byte_index,      |
//           | rsp_data_byte, rsp_has_data, rsp_last   |
// csr       | csr_we, csr_index, csr_wdata            | in, write only
//
// each request is taken as soon as it is offered; the parser holds off data bytes while both
// payload banks wait for replay, and a footer while the frame queue is full
// a good frame replays one result at a time, each through a memory read, then an output load
// reset is synchronous; no clearing pass, payload entries are written before read
// the result register stalls only the replay side; up to two good frames may queue
module framed_packet_receiver import frp_pkg::*; #(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_packet_type,
   output logic [6:0]  rsp_packet_length,
   output logic [5:0]  rsp_byte_index,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_has_data,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic           push;
   logic           pop;
   logic           busy;
   logic [1:0]     q_count;
   logic [1:0]     banks_used;
   frame_desc_type push_desc;
   frame_desc_type q_head;
   store_wr_type   store_wr;

   // banks held by the replay side: queued frames plus the one being replayed
   assign banks_used = q_count + {1'b0, busy};

   // front: byte parser, checksum, csr registers
   frp_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .banks_used  (banks_used),
      .q_count     (q_count),
      .push        (push),
      .push_desc   (push_desc),
      .store_wr    (store_wr)
   );

   // two-deep queue of good frames
   frp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (q_head),
      .count     (q_count)
   );

   // back: payload store and result replay
   frp_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
      .clock             (clock),
      .reset             (reset),
      .store_wr          (store_wr),
      .q_count           (q_count),
      .q_head            (q_head),
      .pop               (pop),
      .busy              (busy),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_packet_type   (rsp_packet_type),
      .rsp_packet_length (rsp_packet_length),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_has_data      (rsp_has_data),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== src/frp_front.sv =====
module frp_front import frp_pkg::*; #(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [7:0]     req_rx_byte,
   input  logic           csr_we,
   input  logic [1:0]     csr_index,
   input  logic [7:0]     csr_wdata,
   input  logic [1:0]     banks_used,
   input  logic [1:0]     q_count,
   output logic           push,
   output frame_desc_type push_desc,
   output store_wr_type   store_wr
);

   localparam int LEN_CAP = (BUFFER_DEPTH < RUN_LIMIT) ? BUFFER_DEPTH : RUN_LIMIT;

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_LEN     = 3'd1;
   localparam logic [2:0] PH_TYPE_HI = 3'd2;
   localparam logic [2:0] PH_TYPE_LO = 3'd3;
   localparam logic [2:0] PH_DATA    = 3'd4;
   localparam logic [2:0] PH_SUM     = 3'd5;
   localparam logic [2:0] PH_FOOT    = 3'd6;

   logic [7:0]  header_ff, footer_ff;
   logic [6:0]  max_len_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  sum_ff, sum_in;
   logic [6:0]  len_ff, len_in;
   logic [6:0]  fill_ff, fill_in;
   logic [15:0] type_ff, type_in;
   logic        bank_ff, bank_in;
   logic        accept;
   logic [6:0]  limit;
   logic [6:0]  fill_next;

   // data bytes wait while both payload banks are held by the replay side,
   // footers wait while the frame queue is full
   assign req_ready = !(((phase_ff == PH_DATA) && (banks_used >= 2'd2)) ||
                        ((phase_ff == PH_FOOT) && (q_count == 2'd2)));
   assign accept    = req_valid && req_ready;

   assign limit     = (max_len_ff < 7'(LEN_CAP)) ? max_len_ff : 7'(LEN_CAP);
   assign fill_next = fill_ff + 7'd1;

   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      len_in   = len_ff;
      fill_in  = fill_ff;
      type_in  = type_ff;
      bank_in  = bank_ff;
      push     = 1'b0;
      store_wr = '{en: 1'b0, bank: bank_ff, idx: fill_ff[5:0], data: req_rx_byte};
      if (accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == header_ff) begin
                  sum_in   = req_rx_byte;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (req_rx_byte > {1'b0, limit}) begin
                  phase_in = PH_HUNT;
               end else begin
                  sum_in   = sum_ff + req_rx_byte;
                  len_in   = req_rx_byte[6:0];
                  fill_in  = 7'd0;
                  phase_in = PH_TYPE_HI;
               end
            end
            PH_TYPE_HI: begin
               sum_in   = sum_ff + req_rx_byte;
               type_in  = {8'h00, req_rx_byte};
               phase_in = PH_TYPE_LO;
            end
            PH_TYPE_LO: begin
               sum_in   = sum_ff + req_rx_byte;
               type_in  = {type_ff[7:0], req_rx_byte};
               phase_in = (len_ff != 7'd0) ? PH_DATA : PH_SUM;
            end
            PH_DATA: begin
               sum_in      = sum_ff + req_rx_byte;
               store_wr.en = 1'b1;
               fill_in     = fill_next;
               if (fill_next >= len_ff) begin
                  phase_in = PH_SUM;
               end
            end
            PH_SUM: begin
               phase_in = (req_rx_byte == sum_ff) ? PH_FOOT : PH_HUNT;
            end
            PH_FOOT: begin
               if (req_rx_byte == footer_ff) begin
                  push    = 1'b1;
                  bank_in = !bank_ff;
               end
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   assign push_desc = '{ptype: type_ff, plen: len_ff, bank: bank_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= HEADER_RESET;
         footer_ff  <= FOOTER_RESET;
         max_len_ff <= MAX_LEN_RESET;
         phase_ff   <= PH_HUNT;
         sum_ff     <= 8'd0;
         len_ff     <= 7'd0;
         fill_ff    <= 7'd0;
         type_ff    <= 16'd0;
         bank_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         len_ff   <= len_in;
         fill_ff  <= fill_in;
         type_ff  <= type_in;
         bank_ff  <= bank_in;
         if (csr_we) begin
            case (csr_index)
               CSR_HEADER:  header_ff  <= csr_wdata;
               CSR_FOOTER:  footer_ff  <= csr_wdata;
               CSR_MAX_LEN: max_len_ff <= csr_wdata[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   // a data byte never lands in a bank still owned by the replay side
   a_wr_bank_free: assert property (@(posedge clock) disable iff (reset)
      store_wr.en |-> (banks_used < 2'd2))
      else $error("payload write while both banks busy");

   // stored index stays inside the frame length
   a_fill_in_len: assert property (@(posedge clock) disable iff (reset)
      store_wr.en |-> (fill_ff < len_ff))
      else $error("payload write beyond frame length");

endmodule

// ===== src/frp_queue.sv =====
module frp_queue import frp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  frame_desc_type push_desc,
   input  logic           pop,
   output frame_desc_type head,
   output logic [1:0]     count
);

   frame_desc_type slot_ff [2];
   logic           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]     count_ff;

   assign head  = slot_ff[rd_ptr_ff];
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2) || pop)
      else $error("frame queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != 2'd0))
      else $error("frame queue underflow");

endmodule

// ===== src/frp_back.sv =====
module frp_back import frp_pkg::*; #(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  store_wr_type   store_wr,
   input  logic [1:0]     q_count,
   input  frame_desc_type q_head,
   output logic           pop,
   output logic           busy,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [15:0]    rsp_packet_type,
   output logic [6:0]     rsp_packet_length,
   output logic [5:0]     rsp_byte_index,
   output logic [7:0]     rsp_data_byte,
   output logic           rsp_has_data,
   output logic           rsp_last
);

   localparam int EFF_DEPTH = (BUFFER_DEPTH < RUN_LIMIT) ? BUFFER_DEPTH : RUN_LIMIT;
   localparam int AW        = (EFF_DEPTH > 1) ? $clog2(EFF_DEPTH) : 1;
   localparam int MEM_DEPTH = 2 ** (AW + 1);

   localparam logic [1:0] BK_IDLE = 2'd0;
   localparam logic [1:0] BK_READ = 2'd1;
   localparam logic [1:0] BK_EMIT = 2'd2;

   logic [7:0]     mem [MEM_DEPTH];
   logic [7:0]     rd_data_ff;
   logic [1:0]     state_ff;
   frame_desc_type cur_ff;
   logic [5:0]     idx_ff;
   logic           out_free;
   logic           is_empty;
   logic           is_last;
   logic           load;

   logic           valid_ff;
   logic [15:0]    type_ff;
   logic [6:0]     len_ff;
   logic [5:0]     oidx_ff;
   logic [7:0]     data_ff;
   logic           has_ff;
   logic           last_ff;

   // two banks, one filled by the parser while the other is replayed
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         mem[{store_wr.bank, store_wr.idx[AW-1:0]}] <= store_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_READ) begin
         rd_data_ff <= mem[{cur_ff.bank, idx_ff[AW-1:0]}];
      end
   end

   assign out_free = !valid_ff || rsp_ready;
   assign is_empty = (cur_ff.plen == 7'd0);
   assign is_last  = is_empty || ({1'b0, idx_ff} + 7'd1 == cur_ff.plen);
   assign load     = (state_ff == BK_EMIT) && out_free;
   assign pop      = (state_ff == BK_IDLE) && (q_count != 2'd0);
   assign busy     = (state_ff != BK_IDLE);

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= q_head;
      end
      if (load) begin
         type_ff <= cur_ff.ptype;
         len_ff  <= cur_ff.plen;
         oidx_ff <= idx_ff;
         data_ff <= is_empty ? 8'd0 : rd_data_ff;
         has_ff  <= !is_empty;
         last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         idx_ff   <= 6'd0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            BK_IDLE: begin
               if (pop) begin
                  idx_ff   <= 6'd0;
                  state_ff <= BK_READ;
               end
            end
            BK_READ: begin
               state_ff <= BK_EMIT;
            end
            BK_EMIT: begin
               if (out_free) begin
                  if (is_last) begin
                     state_ff <= BK_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + 6'd1;
                     state_ff <= BK_READ;
                  end
               end
            end
            default: begin
               state_ff <= BK_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_packet_type   = type_ff;
   assign rsp_packet_length = len_ff;
   assign rsp_byte_index    = oidx_ff;
   assign rsp_data_byte     = data_ff;
   assign rsp_has_data      = has_ff;
   assign rsp_last          = last_ff;

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (load && is_last) |=> (state_ff == BK_IDLE))
      else $error("replay did not release bank after last result");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !has_ff) |-> (last_ff && (data_ff == 8'd0) && (oidx_ff == 6'd0)))
      else $error("empty frame result malformed");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import frp_pkg::*;

   localparam int STORE_DEPTH = BUFFER_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 600;   // long receiver hold-off, fills both payload banks
   localparam int SETTLE_CYCLES = 8;   // quiet cycles before a register write
   localparam int TAIL_CYCLES = 20;    // watch for stray results after the last one is due
   localparam int REPORT_LIMIT = 10;

   // index 3 has no register behind it, writes there must be ignored
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // receiver parsing phases
   typedef enum logic [2:0] {
      HUNT, LENGTH, TYPE_HI, TYPE_LO, PAYLOAD, CHECKSUM, FOOTER
   } parse_state_type;

   // what the sender queue can hold
   typedef enum logic [1:0] {OP_BYTE, OP_CSR, OP_DRAIN, OP_HOLD} stim_kind_type;

   // ways a generated frame can be spoilt
   typedef enum int {CLEAN, BAD_SUM, BAD_FOOT, OVERSIZE} fault_type;

   typedef struct {
      stim_kind_type kind;
      logic [1:0]    index;
      logic [7:0]    value;
   } stim_type;

   // one delivered payload byte (or the lone marker of an empty frame)
   typedef struct packed {
      logic [15:0] ptype;
      logic [6:0]  plen;
      logic [5:0]  idx;
      logic [7:0]  data;
      logic        has_data;
      logic        last;
   } delivery_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_packet_type;
   logic [6:0]  rsp_packet_length;
   logic [5:0]  rsp_byte_index;
   logic [7:0]  rsp_data_byte;
   logic        rsp_has_data;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [7:0]  csr_wdata = 8'd0;

   framed_packet_receiver #(.BUFFER_DEPTH(STORE_DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_packet_type   (rsp_packet_type),
      .rsp_packet_length (rsp_packet_length),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_has_data      (rsp_has_data),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // ---------------------------------------------------------------
   // frame tracker: our own copy of the receiver's registers and state
   // ---------------------------------------------------------------
   logic [7:0]   cfg_header = HEADER_RESET;
   logic [7:0]   cfg_footer = FOOTER_RESET;
   logic [6:0]   cfg_max_len = MAX_LEN_RESET;

   parse_state_type ps = HUNT;
   logic [7:0]   csum = 8'd0;
   logic [6:0]   flen = 7'd0;
   logic [6:0]   fidx = 7'd0;
   logic [15:0]  ftype = 16'd0;
   logic [7:0]   pstore [STORE_DEPTH];

   delivery_type owed_deliveries [$];   // results still to come, oldest first
   int           faults = 0;

   // sender side bookkeeping
   stim_type     stim_q [$];
   int           stim_bytes = 0;
   logic [7:0]   gen_header = HEADER_RESET;
   logic [7:0]   gen_footer = FOOTER_RESET;
   logic [6:0]   gen_max = MAX_LEN_RESET;

   logic         req_fire_q = 1'b0;
   int           gap_left = 0;
   int           tx_calm = 0;
   int           quiet = 0;
   int           hold_req = 0;

   // receiver side bookkeeping
   int           hold_seen = 0;
   int           hold_left = 0;
   int           stall_left = 0;
   int           rx_calm = 0;

   int           cycles = 0;

   // mostly short gaps, now and then a long one
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void apply_csr(input logic [1:0] idx, input logic [7:0] val);
      case (idx)
         CSR_HEADER:  cfg_header = val;
         CSR_FOOTER:  cfg_footer = val;
         CSR_MAX_LEN: cfg_max_len = val[6:0];
         default: ;
      endcase
   endfunction

   // a good footer replays the stored payload, one delivery per byte
   function automatic void release_frame();
      delivery_type d;
      int i;
      if (flen == 7'd0) begin
         d = '{ptype: ftype, plen: 7'd0, idx: 6'd0, data: 8'd0, has_data: 1'b0,
               last: 1'b1};
         owed_deliveries.push_back(d);
      end else begin
         for (i = 0; i < int'(flen) && i < STORE_DEPTH && i < RUN_LIMIT; i++) begin
            d.ptype = ftype;
            d.plen = flen;
            d.idx = i[5:0];
            d.data = pstore[i];
            d.has_data = 1'b1;
            d.last = (i + 1 == int'(flen));
            owed_deliveries.push_back(d);
         end
      end
   endfunction

   // advance the frame tracker by one received byte
   function automatic void absorb_byte(input logic [7:0] b);
      int lim;
      lim = int'(cfg_max_len);
      if (lim > STORE_DEPTH) lim = STORE_DEPTH;
      if (lim > RUN_LIMIT) lim = RUN_LIMIT;
      case (ps)
         HUNT: begin
            if (b == cfg_header) begin
               csum = b;
               ps = LENGTH;
            end
         end
         LENGTH: begin
            // too long for the limit or the store: back to hunting
            if (int'(b) > lim) begin
               ps = HUNT;
            end else begin
               csum = csum + b;
               flen = b[6:0];
               fidx = 7'd0;
               ps = TYPE_HI;
            end
         end
         TYPE_HI: begin
            csum = csum + b;
            ftype = {8'd0, b};
            ps = TYPE_LO;
         end
         TYPE_LO: begin
            csum = csum + b;
            ftype = {ftype[7:0], b};
            ps = (flen > 7'd0) ? PAYLOAD : CHECKSUM;
         end
         PAYLOAD: begin
            csum = csum + b;
            if (int'(fidx) < STORE_DEPTH) pstore[fidx[5:0]] = b;
            fidx = fidx + 7'd1;
            if (fidx >= flen) ps = CHECKSUM;
         end
         CHECKSUM: ps = (b == csum) ? FOOTER : HUNT;
         FOOTER: begin
            if (b == cfg_footer) release_frame();
            ps = HUNT;
         end
         default: ps = HUNT;
      endcase
   endfunction

   // compare one delivered result with the oldest one owed
   function automatic void check_delivery();
      delivery_type got;
      delivery_type want;
      got = '{ptype: rsp_packet_type, plen: rsp_packet_length, idx: rsp_byte_index,
              data: rsp_data_byte, has_data: rsp_has_data, last: rsp_last};
      if (owed_deliveries.size() == 0) begin
         faults++;
         if (faults <= REPORT_LIMIT)
            $display("unexpected result: type %h len %0d idx %0d data %h has %b last %b",
                     got.ptype, got.plen, got.idx, got.data, got.has_data, got.last);
      end else begin
         want = owed_deliveries.pop_front();
         if (got.ptype !== want.ptype || got.plen !== want.plen || got.idx !== want.idx ||
             got.data !== want.data || got.has_data !== want.has_data ||
             got.last !== want.last) begin
            faults++;
            if (faults <= REPORT_LIMIT)
               $display({"mismatch (expected/actual): type %h/%h len %0d/%0d idx %0d/%0d ",
                         "data %h/%h has %b/%b last %b/%b"},
                        want.ptype, got.ptype, want.plen, got.plen, want.idx, got.idx,
                        want.data, got.data, want.has_data, got.has_data,
                        want.last, got.last);
         end
      end
   endfunction

   // ---------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b);
      stim_q.push_back('{kind: OP_BYTE, index: 2'd0, value: b});
      stim_bytes++;
   endtask

   task automatic push_op(input stim_kind_type k);
      stim_q.push_back('{kind: k, index: 2'd0, value: 8'd0});
   endtask

   // the generator keeps its own idea of the settings so frames come out well-formed
   task automatic push_csr(input logic [1:0] idx, input logic [7:0] val);
      stim_q.push_back('{kind: OP_CSR, index: idx, value: val});
      case (idx)
         CSR_HEADER:  gen_header = val;
         CSR_FOOTER:  gen_footer = val;
         CSR_MAX_LEN: gen_max = val[6:0];
         default: ;
      endcase
   endtask

   // pattern below zero gives random payload, otherwise pattern and its inverse alternate
   task automatic push_frame(input int len, input fault_type flt, input logic [15:0] ptype,
                             input int pattern);
      logic [7:0] s;
      logic [7:0] d;
      int i;
      push_byte(gen_header);
      push_byte(len[7:0]);
      if (flt == OVERSIZE) return;
      s = gen_header + len[7:0] + ptype[15:8] + ptype[7:0];
      push_byte(ptype[15:8]);
      push_byte(ptype[7:0]);
      for (i = 0; i < len; i++) begin
         if (pattern < 0) d = $urandom_range(0, 255);
         else d = i[0] ? ~pattern[7:0] : pattern[7:0];
         s = s + d;
         push_byte(d);
      end
      if (flt == BAD_SUM) begin
         push_byte(s ^ 8'($urandom_range(1, 255)));
         push_byte(gen_footer);
      end else begin
         push_byte(s);
         if (flt == BAD_FOOT) begin
            // a bad footer that looks like a header must not open a new frame
            if (gen_header != gen_footer && $urandom_range(0, 1) == 1)
               push_byte(gen_header);
            else
               push_byte(gen_footer ^ 8'($urandom_range(1, 255)));
         end else begin
            push_byte(gen_footer);
         end
      end
   endtask

   // mostly good frames with random content, some spoilt ones and line noise
   task automatic fill_random(input int target);
      int r;
      int lim;
      int len;
      int n;
      int k;
      while (stim_bytes < target) begin
         lim = (int'(gen_max) > RUN_LIMIT) ? RUN_LIMIT : int'(gen_max);
         r = $urandom_range(0, 99);
         if (lim == 0) len = 0;
         else if (r < 70) len = $urandom_range(0, (lim < 6) ? lim : 6);
         else if (r < 92) len = $urandom_range(0, (lim < 20) ? lim : 20);
         else len = $urandom_range(0, lim);
         r = $urandom_range(0, 99);
         if (r < 70) push_frame(len, CLEAN, 16'($urandom_range(0, 65535)), -1);
         else if (r < 80) push_frame(len, BAD_SUM, 16'($urandom_range(0, 65535)), -1);
         else if (r < 90) push_frame(len, BAD_FOOT, 16'($urandom_range(0, 65535)), -1);
         else if (r < 95) push_frame($urandom_range(lim + 1, 255), OVERSIZE, 16'd0, -1);
         else begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               k = $urandom_range(0, 255);
               if (k[7:0] != gen_header) push_byte(k[7:0]);
            end
         end
         // now and then the sender waits until every owed result is in
         if ($urandom_range(0, 99) < 4) push_op(OP_DRAIN);
      end
   endtask

   // ---------------------------------------------------------------
   // clock
   // ---------------------------------------------------------------
   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // request driver: changes inputs on the falling edge
   // ---------------------------------------------------------------
   always @(negedge clock) begin : request_driver
      logic v;
      logic we;
      v = req_valid;
      we = 1'b0;
      if (!req_valid && owed_deliveries.size() == 0) quiet++;
      else quiet = 0;
      if (reset) begin
         v = 1'b0;
      end else if (req_valid && !req_fire_q) begin
         // request still waiting for its handshake, hold it steady
         v = 1'b1;
      end else begin
         v = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (stim_q.size() > 0) begin
            case (stim_q[0].kind)
               OP_BYTE: begin
                  v = 1'b1;
                  req_rx_byte <= stim_q[0].value;
                  void'(stim_q.pop_front());
                  if (tx_calm > 0) begin
                     tx_calm--;
                     gap_left = 0;
                  end else begin
                     gap_left = draw_gap();
                     if ($urandom_range(0, 19) == 0) tx_calm = $urandom_range(20, 60);
                  end
               end
               OP_CSR: begin
                  // registers only change once the block has gone quiet
                  if (owed_deliveries.size() == 0 && quiet >= SETTLE_CYCLES) begin
                     we = 1'b1;
                     csr_index <= stim_q[0].index;
                     csr_wdata <= stim_q[0].value;
                     void'(stim_q.pop_front());
                  end
               end
               OP_DRAIN: begin
                  if (owed_deliveries.size() == 0) void'(stim_q.pop_front());
               end
               OP_HOLD: begin
                  // ask the receiver for its long hold-off, keep sending meanwhile
                  hold_req <= hold_req + 1;
                  void'(stim_q.pop_front());
               end
               default: void'(stim_q.pop_front());
            endcase
         end
      end
      req_valid <= v;
      csr_we <= we;
   end

   // ---------------------------------------------------------------
   // result receiver: random stalls plus one long hold-off
   // ---------------------------------------------------------------
   always @(negedge clock) begin : result_taker
      logic r;
      if (reset) begin
         r = 1'b0;
      end else if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
         r = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         r = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         r = 1'b0;
      end else begin
         r = 1'b1;
         if (rx_calm > 0) begin
            rx_calm--;
         end else begin
            stall_left = draw_gap();
            if ($urandom_range(0, 19) == 0) rx_calm = $urandom_range(20, 60);
         end
      end
      rsp_ready <= r;
   end

   // ---------------------------------------------------------------
   // monitor: samples everything on the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      req_fire_q <= req_valid && req_ready;
      if (!reset) begin
         if (csr_we) apply_csr(csr_index, csr_wdata);
         if (req_valid && req_ready) absorb_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) check_delivery();
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus plan, reset and end of run
   // ---------------------------------------------------------------
   initial begin : plan
      logic [7:0] h;
      logic [7:0] f;
      logic [7:0] s;

      // directed part, reset settings
      push_frame(0, CLEAN, 16'hFFFF, -1);        // empty frame, all-ones type
      push_frame(2, CLEAN, 16'h0000, 8'hFF);     // payload extremes, zero type
      push_frame(65, OVERSIZE, 16'd0, -1);       // one past the store
      // footer changed half way through a frame, takes effect on the next byte
      s = gen_header + 8'd1 + 8'h12 + 8'h34 + 8'h5A;
      push_byte(gen_header);
      push_byte(8'd1);
      push_csr(CSR_FOOTER, 8'h3C);
      push_byte(8'h12);
      push_byte(8'h34);
      push_byte(8'h5A);
      push_byte(s);
      push_byte(8'h3C);
      push_op(OP_DRAIN);

      // all-zero header, all-ones footer, only empty frames allowed
      push_csr(CSR_HEADER, 8'h00);
      push_csr(CSR_FOOTER, 8'hFF);
      push_csr(CSR_MAX_LEN, 8'h00);
      push_csr(CSR_UNUSED, 8'hA5);
      fill_random(70);
      push_op(OP_DRAIN);

      // swapped extremes, length limit written above what the store allows
      push_csr(CSR_HEADER, 8'hFF);
      push_csr(CSR_FOOTER, 8'h00);
      push_csr(CSR_MAX_LEN, 8'hFF);
      push_op(OP_HOLD);
      push_frame(64, CLEAN, 16'($urandom_range(0, 65535)), -1);
      push_frame(8, CLEAN, 16'($urandom_range(0, 65535)), -1);
      push_frame(8, CLEAN, 16'($urandom_range(0, 65535)), -1);
      push_frame(5, CLEAN, 16'($urandom_range(0, 65535)), -1);
      push_frame(65, OVERSIZE, 16'd0, -1);
      fill_random(190);
      push_op(OP_DRAIN);

      // random distinct header and footer, random limit
      h = $urandom_range(0, 255);
      do f = $urandom_range(0, 255); while (f == h);
      push_csr(CSR_HEADER, h);
      push_csr(CSR_FOOTER, f);
      push_csr(CSR_MAX_LEN, 8'($urandom_range(1, 64)));
      fill_random(265);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every request out, every owed result in, then a short tail
      while (stim_q.size() > 0 || req_valid) @(posedge clock);
      while (owed_deliveries.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (faults == 0 && owed_deliveries.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
